[rtl/wfs_pkg.sv]
// Shared types, constants and helpers for the wire-follow steering block.
// No dependencies; every other file of the block refers to it by scoped names.
package wfs_pkg;

  localparam int MagW     = 16;  // signed wire magnitude
  localparam int DtW      = 16;  // elapsed milliseconds per tick
  localparam int SpdW     = 8;   // wheel duty / full speed
  localparam int MaxMagW  = 15;  // magnitude cap
  localparam int TurnW    = 16;  // turn limits
  localparam int TimeW    = 32;  // saturating timers, tracking limit
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Slowdown divider: dividend is a 15x12 product, divisor is up to 5*cap.
  localparam int OpaW     = 15;
  localparam int OpbW     = 12;
  localparam int DivW     = OpaW + OpbW;
  localparam int DvsW     = 18;
  localparam int DivSteps = DivW;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_MUL,
    S_DIV,
    S_TURN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    DIR_FORWARD    = 2'd0,
    DIR_SPIN_LEFT  = 2'd1,
    DIR_SPIN_RIGHT = 2'd2,
    DIR_STOPPED    = 2'd3
  } dir_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CCW_ENABLE   = 3'd0,
    CFG_MAX_MAG      = 3'd1,
    CFG_FULL_SPEED   = 3'd2,
    CFG_MAX_LEFT_MS  = 3'd3,
    CFG_MAX_RIGHT_MS = 3'd4,
    CFG_MAX_TRACK_MS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Saturating add of a timer and a tick duration.
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [DtW-1:0] b);
    logic [TimeW:0] sum;
    sum = {1'b0, a} + {{(TimeW+1-DtW){1'b0}}, b};
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

endpackage

[rtl/wfs_if.sv]
// Valid/ready channel interfaces for the wire-follow steering block.
// Depends on wfs_pkg for field widths.
interface wfs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [wfs_pkg::MagW-1:0]   magnitude;
  logic                              inside_req;
  logic        [wfs_pkg::DtW-1:0]    elapsed_ms;

  modport source(output valid, magnitude, inside_req, elapsed_ms, input ready);
  modport sink(input valid, magnitude, inside_req, elapsed_ms, output ready);
endinterface

interface wfs_out_if;
  logic                       valid;
  logic                       ready;
  logic [wfs_pkg::SpdW-1:0]   duty_l;
  logic [wfs_pkg::SpdW-1:0]   duty_r;
  logic [1:0]                 direction;
  logic                       done_res;

  modport source(output valid, duty_l, duty_r, direction, done_res, input ready);
  modport sink(input valid, duty_l, duty_r, direction, done_res, output ready);
endinterface

interface wfs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wfs_pkg::CfgIdxW-1:0]   index;
  logic [wfs_pkg::CfgDataW-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/wfs_div.sv]
// Restoring divider, one quotient bit per cycle, for the steering slowdown.
// Depends on wfs_pkg for widths and the status struct.
module wfs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wfs_pkg::DivW-1:0]      dividend,
  input  logic [wfs_pkg::DvsW-1:0]      divisor,
  output logic [wfs_pkg::DivW-1:0]      quotient,
  output wfs_pkg::div_status_t          status
);

  logic [wfs_pkg::DivW-1:0]    quo_r, quo_nxt;
  logic [wfs_pkg::DvsW-1:0]    rem_r, rem_nxt;
  logic [wfs_pkg::DvsW-1:0]    dvs_r;
  logic [wfs_pkg::DivCntW-1:0] cnt_r;
  logic                        busy_r, done_r;
  logic [wfs_pkg::DvsW:0]      trial;
  logic [wfs_pkg::DvsW:0]      diff;
  logic                        take;

  // One compare-subtract step: shift in the next dividend bit.
  always_comb begin
    trial   = {rem_r, quo_r[wfs_pkg::DivW-1]};
    diff    = trial - {1'b0, dvs_r};
    take    = (trial >= {1'b0, dvs_r});
    rem_nxt = take ? diff[wfs_pkg::DvsW-1:0] : trial[wfs_pkg::DvsW-1:0];
    quo_nxt = {quo_r[wfs_pkg::DivW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == wfs_pkg::DivCntW'(wfs_pkg::DivSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

[rtl/wire_follow_steering.sv]
// Top level of the wire-follow steering block: sequencer, state and registers.
// Depends on wfs_pkg, the channel interfaces in wfs_if and the divider wfs_div.
//
// Each input beat is one sensor tick (signed magnitude, inside flag, elapsed ms)
// and produces exactly one result beat (two wheel duties, direction, done).
// The block takes one tick at a time. A tick that steers (CCW enable set, not
// finished, limit not reached on this tick, nonzero magnitude) goes through the
// tracking timer step, the multiply, the bit-serial slowdown division (27
// quotient steps and one to flag completion), the turn-limit decision and the
// load of the result register. The next tick is taken once the result is loaded.
// Any other tick goes from the tracking timer step straight to the result load.
// The result register lets the next tick enter while a finished result still
// waits for the sink; the sequencer only stalls when a second result is ready
// before the first has been taken.
// Configuration writes are always taken and must only come while the block is
// idle. Once the tracking limit is reached the block reports done with both
// wheels stopped on every tick until reset.
module wire_follow_steering (
  input  logic          clk,
  input  logic          rst_n,
  wfs_in_if.sink        in_ch,
  wfs_out_if.source     out_ch,
  wfs_cfg_if.sink       cfg_ch
);

  // Configuration registers
  logic                           ccw_en_r;
  logic [wfs_pkg::MaxMagW-1:0]    max_mag_r;
  logic [wfs_pkg::SpdW-1:0]       speed_r;
  logic [wfs_pkg::TurnW-1:0]      max_left_r;
  logic [wfs_pkg::TurnW-1:0]      max_right_r;
  logic [wfs_pkg::TimeW-1:0]      max_track_r;

  // Sequencer and latched tick
  wfs_pkg::state_t                state_r, state_nxt;
  logic signed [wfs_pkg::MagW-1:0] mag_r;
  logic                           inside_r;
  logic [wfs_pkg::DtW-1:0]        dt_r;

  // Steering state
  logic                           last_inside_r, last_inside_nxt;
  logic [wfs_pkg::TimeW-1:0]      left_time_r, left_time_nxt;
  logic [wfs_pkg::TimeW-1:0]      right_time_r, right_time_nxt;
  logic [wfs_pkg::TimeW-1:0]      run_time_r, run_time_nxt;
  logic [wfs_pkg::SpdW-1:0]       left_duty_r, left_duty_nxt;
  logic [wfs_pkg::SpdW-1:0]       right_duty_r, right_duty_nxt;
  wfs_pkg::dir_t                  mode_r, mode_nxt;
  logic                           finished_r, finished_nxt;

  // Result register
  logic                           out_vld_r, out_vld_nxt;
  logic [wfs_pkg::SpdW-1:0]       out_left_r, out_right_r;
  wfs_pkg::dir_t                  out_dir_r;
  logic                           out_done_r;
  logic                           out_load;

  // Datapath helpers
  logic                           in_acc;
  logic                           mag_pos;
  logic                           mag_zero;
  logic [wfs_pkg::TimeW-1:0]      run_sum;
  logic                           track_on;
  logic                           fin_now;
  logic                           go;
  logic [wfs_pkg::MaxMagW-1:0]    mx;
  logic [wfs_pkg::OpaW-1:0]       opa;
  logic [wfs_pkg::OpbW-1:0]       opb;
  logic signed [wfs_pkg::MagW:0]  mag_ofs;
  logic [wfs_pkg::MagW:0]         mag_abs;
  logic [wfs_pkg::DivW-1:0]       product;
  logic [wfs_pkg::DvsW-1:0]       divisor;
  logic [wfs_pkg::DivW-1:0]       quotient;
  wfs_pkg::div_status_t           div_st;
  logic                           div_start;
  logic [wfs_pkg::SpdW-1:0]       slow;

  assign in_ch.ready  = (state_r == wfs_pkg::S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign mag_pos  = !mag_r[wfs_pkg::MagW-1];
  assign mag_zero = (mag_r == '0);

  // Tracking timer and finish decision
  assign track_on = !finished_r && (max_track_r != '0);
  assign run_sum  = wfs_pkg::sat_add(run_time_r, dt_r);
  assign fin_now  = track_on && (run_sum >= max_track_r);
  assign go       = !(finished_r || fin_now) && !mag_zero;

  // Multiplier operands: capped magnitude times 9*speed, or |m+100| times speed
  assign mx      = (max_mag_r == '0) ? wfs_pkg::MaxMagW'(1) : max_mag_r;
  assign mag_ofs = {mag_r[wfs_pkg::MagW-1], mag_r} + (wfs_pkg::MagW+1)'(100);
  assign mag_abs = mag_ofs[wfs_pkg::MagW] ? (wfs_pkg::MagW+1)'(-mag_ofs)
                                          : (wfs_pkg::MagW+1)'(mag_ofs);

  always_comb begin
    if (mag_pos) begin
      opa = ($unsigned(mag_r) > {1'b0, mx}) ? mx : mag_r[wfs_pkg::OpaW-1:0];
      opb = {1'b0, speed_r, 3'b000} + {4'b0000, speed_r};
      divisor = {1'b0, mx, 2'b00} + {3'b000, mx};
    end else begin
      opa = mag_abs[wfs_pkg::OpaW-1:0];
      opb = {4'b0000, speed_r};
      divisor = {3'b000, mx};
    end
  end

  assign product   = opa * opb;
  assign div_start = (state_r == wfs_pkg::S_MUL);

  wfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (divisor),
    .quotient (quotient),
    .status   (div_st)
  );

  // Clamp the slowdown to the speed ceiling
  assign slow = (quotient > {{(wfs_pkg::DivW-wfs_pkg::SpdW){1'b0}}, speed_r})
                ? speed_r : quotient[wfs_pkg::SpdW-1:0];

  assign out_load = (state_r == wfs_pkg::S_OUT) && (!out_vld_r || out_ch.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wfs_pkg::S_IDLE: if (in_acc) state_nxt = wfs_pkg::S_RUN;
      wfs_pkg::S_RUN:  state_nxt = (go && ccw_en_r) ? wfs_pkg::S_MUL : wfs_pkg::S_OUT;
      wfs_pkg::S_MUL:  state_nxt = wfs_pkg::S_DIV;
      wfs_pkg::S_DIV:  if (div_st.done) state_nxt = wfs_pkg::S_TURN;
      wfs_pkg::S_TURN: state_nxt = wfs_pkg::S_OUT;
      wfs_pkg::S_OUT:  if (out_load) state_nxt = wfs_pkg::S_IDLE;
      default:         state_nxt = wfs_pkg::S_IDLE;
    endcase
  end

  // State updates per sequencer step
  always_comb begin
    last_inside_nxt = last_inside_r;
    left_time_nxt   = left_time_r;
    right_time_nxt  = right_time_r;
    run_time_nxt    = run_time_r;
    left_duty_nxt   = left_duty_r;
    right_duty_nxt  = right_duty_r;
    mode_nxt        = mode_r;
    finished_nxt    = finished_r;
    unique case (state_r)
      wfs_pkg::S_RUN: begin
        // Advance the tracking timer; stop the motors at the limit
        if (track_on) run_time_nxt = run_sum;
        if (fin_now) begin
          finished_nxt   = 1'b1;
          left_duty_nxt  = '0;
          right_duty_nxt = '0;
          mode_nxt       = wfs_pkg::DIR_STOPPED;
        end
        // Inside flip clears both turn timers, even with tracking off
        if (go && (last_inside_r != inside_r)) begin
          left_time_nxt   = '0;
          right_time_nxt  = '0;
          last_inside_nxt = inside_r;
        end
      end
      wfs_pkg::S_MUL: begin
        // Accumulate the turning side, clear the other
        if (mag_pos) begin
          right_time_nxt = '0;
          left_time_nxt  = wfs_pkg::sat_add(left_time_r, dt_r);
        end else begin
          left_time_nxt  = '0;
          right_time_nxt = wfs_pkg::sat_add(right_time_r, dt_r);
        end
      end
      wfs_pkg::S_TURN: begin
        if (mag_pos) begin
          if (left_time_r > {{(wfs_pkg::TimeW-wfs_pkg::TurnW){1'b0}}, max_left_r}) begin
            left_duty_nxt  = speed_r;
            right_duty_nxt = speed_r;
            mode_nxt       = wfs_pkg::DIR_SPIN_LEFT;
          end else begin
            left_duty_nxt  = speed_r - slow;
            right_duty_nxt = speed_r;
            mode_nxt       = wfs_pkg::DIR_FORWARD;
          end
        end else begin
          if (right_time_r > {{(wfs_pkg::TimeW-wfs_pkg::TurnW){1'b0}}, max_right_r}) begin
            left_duty_nxt  = speed_r;
            right_duty_nxt = speed_r;
            mode_nxt       = wfs_pkg::DIR_SPIN_RIGHT;
          end else begin
            left_duty_nxt  = speed_r;
            right_duty_nxt = speed_r - slow;
            mode_nxt       = wfs_pkg::DIR_FORWARD;
          end
        end
      end
      default: ;
    endcase
  end

  // Result register valid: drop on a taken beat, set on load
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ch.ready) out_vld_nxt = 1'b0;
    if (out_load) out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= wfs_pkg::S_IDLE;
      ccw_en_r      <= 1'b1;
      max_mag_r     <= wfs_pkg::MaxMagW'(2000);
      speed_r       <= wfs_pkg::SpdW'(255);
      max_left_r    <= wfs_pkg::TurnW'(3000);
      max_right_r   <= wfs_pkg::TurnW'(3000);
      max_track_r   <= '0;
      last_inside_r <= 1'b0;
      left_time_r   <= '0;
      right_time_r  <= '0;
      run_time_r    <= '0;
      left_duty_r   <= '0;
      right_duty_r  <= '0;
      mode_r        <= wfs_pkg::DIR_FORWARD;
      finished_r    <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_inside_r <= last_inside_nxt;
      left_time_r   <= left_time_nxt;
      right_time_r  <= right_time_nxt;
      run_time_r    <= run_time_nxt;
      left_duty_r   <= left_duty_nxt;
      right_duty_r  <= right_duty_nxt;
      mode_r        <= mode_nxt;
      finished_r    <= finished_nxt;
      out_vld_r     <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          wfs_pkg::CFG_CCW_ENABLE:   ccw_en_r    <= cfg_ch.data[0];
          wfs_pkg::CFG_MAX_MAG:      max_mag_r   <= cfg_ch.data[wfs_pkg::MaxMagW-1:0];
          wfs_pkg::CFG_FULL_SPEED:   speed_r     <= cfg_ch.data[wfs_pkg::SpdW-1:0];
          wfs_pkg::CFG_MAX_LEFT_MS:  max_left_r  <= cfg_ch.data[wfs_pkg::TurnW-1:0];
          wfs_pkg::CFG_MAX_RIGHT_MS: max_right_r <= cfg_ch.data[wfs_pkg::TurnW-1:0];
          wfs_pkg::CFG_MAX_TRACK_MS: max_track_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: latch the tick, load the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_r    <= in_ch.magnitude;
      inside_r <= in_ch.inside_req;
      dt_r     <= in_ch.elapsed_ms;
    end
    if (out_load) begin
      out_left_r  <= left_duty_r;
      out_right_r <= right_duty_r;
      out_dir_r   <= mode_r;
      out_done_r  <= finished_r;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.duty_l    = out_left_r;
  assign out_ch.duty_r    = out_right_r;
  assign out_ch.direction = out_dir_r;
  assign out_ch.done_res  = out_done_r;

  // Finished is sticky until reset
  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag dropped");

  // A done result always carries stopped motors
  a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_done_r) |->
      (out_left_r == '0 && out_right_r == '0 && out_dir_r == wfs_pkg::DIR_STOPPED))
    else $error("done result with running motors");

  // The divider is idle whenever a new tick is taken
  a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !div_st.busy)
    else $error("tick accepted while divider busy");

  // Divider completion only lands while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == wfs_pkg::S_DIV))
    else $error("divider done outside divide step");

endmodule
